// ===== sv/lss_pkg.sv =====
package lss_pkg;

   // Stack geometry
   localparam int DEPTH   = 64;
   localparam int WORD_W  = 32;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int PTR_W   = $clog2(DEPTH + 1);

   // Fixed field widths
   localparam int KIND_W  = 3;
   localparam int CAP_W   = 7;
   localparam int COUNT_W = 7;
   localparam int IDX_W   = 6;

   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH   = 3'd0,
      KIND_POP    = 3'd1,
      KIND_PEEK   = 3'd2,
      KIND_CLEAR  = 3'd3,
      KIND_SEARCH = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_EMPTY    = 2'd2,
      STATUS_NOTFOUND = 2'd3
   } status_type;

   // One result beat
   typedef struct packed {
      status_type         status;
      logic [WORD_W-1:0]  data;
      logic [IDX_W-1:0]   found_index;
      logic [COUNT_W-1:0] count;
      logic               is_empty;
      logic               is_full;
   } result_type;

   // Capacity saturated to the physical depth
   function automatic logic [PTR_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
      if (int'(cap) > DEPTH) begin
         return PTR_W'(DEPTH);
      end else begin
         return PTR_W'(cap);
      end
   endfunction

endpackage

// ===== sv/lifo_stack_with_search.sv =====
// LIFO stack of signed 32-bit words with a top-down key search.
// Request channel (req_): kind and value; a beat is taken when req_valid is
// high and req_stall is low. Result channel (rsp_): status, data,
// found_index, count, is_empty, is_full; the downstream side drives
// rsp_stall. Capacity register (csr_): written whenever csr_valid is high
// (csr_ready is tied high); change it only while the block is idle.
// Request beat to result beat, by kind:
//   push, clear, failed requests and unknown kinds: answered from the idle
//   state, 1 beat/cycle while req_stall is low; pop and peek: one memory
//   read in ST_READ, no new request taken meanwhile; search: scans down
//   from the top to a match or the bottom entry, one stored entry read per
//   cycle through the single read port of the stack memory.
// The result path holds an output register plus one skid entry, so a
// request can be taken while a result waits; once both are occupied,
// req_stall stays high until rsp_stall drops. Reset empties the stack and
// sets capacity to 64; memory contents are not cleared.
module lifo_stack_with_search
   import lss_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic signed [WORD_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [WORD_W-1:0] rsp_data,
   output logic [IDX_W-1:0]         rsp_found_index,
   output logic [COUNT_W-1:0]       rsp_count,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CAP_W-1:0]         csr_data
);

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [WORD_W-1:0] rd_data;
   logic              res_valid;
   logic              res_ready;
   result_type        res;
   result_type        rsp;

   // Stack storage
   lss_ram #(
      .WIDTH   (WORD_W),
      .ENTRIES (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Request sequencer
   lss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_kind  (req_kind),
      .req_value (req_value),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .res_valid (res_valid),
      .res       (res),
      .res_ready (res_ready)
   );

   // Result buffer
   lss_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_res    (res),
      .in_ready  (res_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_status      = rsp.status;
   assign rsp_data        = rsp.data;
   assign rsp_found_index = rsp.found_index;
   assign rsp_count       = rsp.count;
   assign rsp_is_empty    = rsp.is_empty;
   assign rsp_is_full     = rsp.is_full;

endmodule

// ===== sv/lss_ram.sv =====
module lss_ram #(
   parameter int WIDTH   = 32,
   parameter int ENTRIES = 64
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [ENTRIES];

   // Single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== sv/lss_ctrl.sv =====
module lss_ctrl
   import lss_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [KIND_W-1:0]       req_kind,
   input  logic signed [WORD_W-1:0] req_value,
   // capacity register
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CAP_W-1:0]        csr_data,
   // stack memory
   output logic                    wr_en,
   output logic [ADDR_W-1:0]       wr_addr,
   output logic [WORD_W-1:0]       wr_data,
   output logic                    rd_en,
   output logic [ADDR_W-1:0]       rd_addr,
   input  logic [WORD_W-1:0]       rd_data,
   // result toward output buffer
   output logic                    res_valid,
   output result_type              res,
   input  logic                    res_ready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN
   } state_type;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   sp_ff, sp_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic [ADDR_W-1:0]  scan_ff, scan_in;
   logic [WORD_W-1:0]  key_ff, key_in;

   logic [PTR_W-1:0]   cap_eff;
   logic [PTR_W-1:0]   sp_dec;
   logic [ADDR_W-1:0]  top_addr;
   logic [ADDR_W-1:0]  scan_dec;
   logic               accept;
   kind_type           kind;
   status_type         status;
   logic [WORD_W-1:0]  data;
   logic [IDX_W-1:0]   fidx;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE) || !res_ready;
   assign accept    = req_valid && !req_stall;
   assign kind      = kind_type'(req_kind);
   assign cap_eff   = eff_cap(cap_ff);
   assign sp_dec    = sp_ff - PTR_W'(1);
   assign top_addr  = sp_dec[ADDR_W-1:0];
   assign scan_dec  = scan_ff - ADDR_W'(1);

   // Pushes write at the top while the request is taken
   assign wr_addr = sp_ff[ADDR_W-1:0];
   assign wr_data = req_value;

   // Sequencer: one entry read per cycle
   always_comb begin
      state_in  = state_ff;
      sp_in     = sp_ff;
      scan_in   = scan_ff;
      key_in    = key_ff;
      cap_in    = cap_ff;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = top_addr;
      res_valid = 1'b0;
      status    = STATUS_OK;
      data      = '0;
      fidx      = '0;

      if (csr_valid && csr_ready) begin
         cap_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (kind)
                  KIND_PUSH: begin
                     res_valid = 1'b1;
                     if (sp_ff >= cap_eff) begin
                        status = STATUS_FULL;
                     end else begin
                        wr_en = 1'b1;
                        sp_in = sp_ff + PTR_W'(1);
                     end
                  end
                  KIND_POP: begin
                     if (sp_ff == '0) begin
                        status    = STATUS_EMPTY;
                        res_valid = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        sp_in    = sp_dec;
                        state_in = ST_READ;
                     end
                  end
                  KIND_PEEK: begin
                     if (sp_ff == '0) begin
                        status    = STATUS_EMPTY;
                        res_valid = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = ST_READ;
                     end
                  end
                  KIND_CLEAR: begin
                     sp_in     = '0;
                     res_valid = 1'b1;
                  end
                  KIND_SEARCH: begin
                     if (sp_ff == '0) begin
                        status    = STATUS_NOTFOUND;
                        res_valid = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        scan_in  = top_addr;
                        key_in   = req_value;
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     res_valid = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            data      = rd_data;
            res_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_SCAN: begin
            if (rd_data == key_ff) begin
               fidx      = IDX_W'(scan_ff);
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end else if (scan_ff == '0) begin
               status    = STATUS_NOTFOUND;
               res_valid = 1'b1;
               state_in  = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = scan_dec;
               scan_in = scan_dec;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result fields reflect the pointer after this request
   always_comb begin
      res.status      = status;
      res.data        = data;
      res.found_index = fidx;
      res.count       = COUNT_W'(sp_in);
      res.is_empty    = (sp_in == '0);
      res.is_full     = (sp_in >= cap_eff);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sp_ff    <= '0;
         cap_ff   <= CAP_RESET;
      end else begin
         state_ff <= state_in;
         sp_ff    <= sp_in;
         cap_ff   <= cap_in;
      end
   end

   // Scan payload
   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      key_ff  <= key_in;
   end

endmodule

// ===== sv/lss_out.sv =====
module lss_out
   import lss_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  result_type in_res,
   output logic       in_ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       take;

   assign take      = out_valid_ff && !rsp_stall;
   assign in_ready  = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

   // Output register with one skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_valid_ff && !take) begin
         if (in_valid && in_ready) begin
            skid_in       = in_res;
            skid_valid_in = 1'b1;
         end
      end else if (skid_valid_ff) begin
         out_in        = skid_ff;
         out_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
      end else begin
         out_in       = in_res;
         out_valid_in = in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

// ===== sv/lss_checker.sv =====
module lss_checker
   import lss_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic [1:0]               rsp_status,
   input logic signed [WORD_W-1:0] rsp_data,
   input logic [IDX_W-1:0]         rsp_found_index,
   input logic [COUNT_W-1:0]       rsp_count,
   input logic                     rsp_is_empty,
   input logic                     rsp_is_full
);

   // Held result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_data)
         && $stable(rsp_count) && $stable(rsp_found_index))
      else $error("result beat changed while stalled");

   // Empty flag tracks the count
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_empty == (rsp_count == '0))
      else $error("is_empty does not match count");

   // A refused push means the stack is at capacity
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> rsp_is_full && (rsp_data == '0))
      else $error("full status without full flag");

   // Pop or peek on an empty stack returns nothing
   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY) |->
         rsp_is_empty && (rsp_data == '0) && (rsp_found_index == '0))
      else $error("empty status with data or nonzero count");

endmodule

bind lifo_stack_with_search lss_checker u_lss_checker (.*);

// ===== verif/lifo_stack_with_search_tb.sv =====
module lifo_stack_with_search_tb
   import lss_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [KIND_W-1:0] KIND_LAST = KIND_W'((1 << KIND_W) - 1);

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [KIND_W-1:0]        req_kind;
   logic signed [WORD_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [1:0]               rsp_status;
   logic signed [WORD_W-1:0] rsp_data;
   logic [IDX_W-1:0]         rsp_found_index;
   logic [COUNT_W-1:0]       rsp_count;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CAP_W-1:0]         csr_data;

   // Shadow copy of the stack and its capacity register
   logic [WORD_W-1:0] stack_shadow [DEPTH];
   int                shadow_count;
   logic [CAP_W-1:0]  shadow_capacity;

   result_type pending_results[$];

   int error_count;
   int results_checked;
   int idle_cycles;
   int burst_left;
   int full_rejects;
   int empty_rejects;
   int search_hits;
   int search_misses;
   int deepest_stack;
   int capacity_writes;
   int drain_pauses;

   lifo_stack_with_search u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_data        (rsp_data),
      .rsp_found_index (rsp_found_index),
      .rsp_count       (rsp_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Work out the result of one request and update the shadow stack
   function automatic void predict_stack_result(input logic [KIND_W-1:0] kind,
                                                input logic [WORD_W-1:0] value);
      result_type r;
      int         limit;
      int         idx;
      bit         hit;
      limit = (int'(shadow_capacity) > DEPTH) ? DEPTH : int'(shadow_capacity);
      r = '0;
      r.status = STATUS_OK;
      case (kind)
         KIND_PUSH: begin
            if (shadow_count >= limit) begin
               r.status = STATUS_FULL;
               full_rejects++;
            end else begin
               stack_shadow[shadow_count] = value;
               shadow_count++;
            end
         end
         KIND_POP: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY;
               empty_rejects++;
            end else begin
               shadow_count--;
               r.data = stack_shadow[shadow_count];
            end
         end
         KIND_PEEK: begin
            if (shadow_count == 0) begin
               r.status = STATUS_EMPTY;
               empty_rejects++;
            end else begin
               r.data = stack_shadow[shadow_count - 1];
            end
         end
         KIND_CLEAR: begin
            shadow_count = 0;
         end
         KIND_SEARCH: begin
            // top-down scan, first hit wins
            hit = 1'b0;
            idx = shadow_count;
            while (idx > 0 && !hit) begin
               idx--;
               if (stack_shadow[idx] == value) hit = 1'b1;
            end
            if (hit) begin
               r.found_index = IDX_W'(idx);
               search_hits++;
            end else begin
               r.status = STATUS_NOTFOUND;
               search_misses++;
            end
         end
         default: begin
            // reserved kinds do nothing
         end
      endcase
      r.count    = COUNT_W'(shadow_count);
      r.is_empty = (shadow_count == 0);
      r.is_full  = (shadow_count >= limit);
      if (shadow_count > deepest_stack) deepest_stack = shadow_count;
      pending_results.push_back(r);
   endfunction

   // Edge monitor: track accepted beats, check results, run the watchdog
   always @(posedge clock) begin : beat_monitor
      result_type want;
      logic       moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            shadow_capacity = csr_data;
            moved = 1'b1;
         end
         if (req_valid && !req_stall) begin
            predict_stack_result(req_kind, req_value);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (pending_results.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("ERROR: result beat with nothing pending: status=%0d data=%h",
                           rsp_status, rsp_data);
            end else begin
               want = pending_results.pop_front();
               results_checked++;
               if (rsp_status !== want.status || rsp_data !== want.data ||
                   rsp_found_index !== want.found_index || rsp_count !== want.count ||
                   rsp_is_empty !== want.is_empty || rsp_is_full !== want.is_full) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT) begin
                     $display({"ERROR: result %0d exp status=%0d data=%h idx=%0d",
                               " count=%0d empty=%b full=%b"},
                              results_checked, want.status, want.data, want.found_index,
                              want.count, want.is_empty, want.is_full);
                     $display("       got status=%0d data=%h idx=%0d count=%0d empty=%b full=%b",
                              rsp_status, rsp_data, rsp_found_index, rsp_count,
                              rsp_is_empty, rsp_is_full);
                  end
               end
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, %0d results pending",
                     idle_cycles, pending_results.size());
            $display("lifo_stack_with_search_tb: FAIL");
            $finish;
         end
      end
   end

   // Receiver back-pressure in random modes, each held for a random span
   initial begin : rsp_stall_pattern
      int mode;
      int span;
      int phase;
      rsp_stall = 1'b0;
      phase = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 150);
         repeat (span) begin
            @(negedge clock);
            phase++;
            case (mode)
               0:       rsp_stall = 1'b0;
               1:       rsp_stall = ($urandom_range(0, 99) < 30);
               2:       rsp_stall = ($urandom_range(0, 99) < 75);
               default: rsp_stall = ((phase % 5) < 3);
            endcase
         end
      end
   end

   // Send one request beat; bursts of random length with idle gaps between them
   task automatic send_request(input logic [KIND_W-1:0] kind, input logic [WORD_W-1:0] value);
      if (burst_left == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
      end
      burst_left--;
      req_valid = 1'b1;
      req_kind  = kind;
      req_value = value;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic drain_results();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      drain_results();
      csr_valid = 1'b1;
      csr_data  = cap;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
      capacity_writes++;
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      logic [WORD_W-1:0] w;
      case ($urandom_range(0, 7))
         0, 1: begin
            // narrow range so duplicates show up on the stack
            w = $urandom_range(0, 8);
            w = w - WORD_W'(4);
         end
         2: begin
            case ($urandom_range(0, 3))
               0:       w = {1'b1, {(WORD_W-1){1'b0}}};
               1:       w = {1'b0, {(WORD_W-1){1'b1}}};
               2:       w = '0;
               default: w = '1;
            endcase
         end
         default: w = $urandom();
      endcase
      return w;
   endfunction

   // Search keys mostly taken from live entries so hits land at every depth
   function automatic logic [WORD_W-1:0] pick_key();
      if (shadow_count > 0 && $urandom_range(0, 2) != 0)
         return stack_shadow[$urandom_range(0, shadow_count - 1)];
      return pick_word();
   endfunction

   task automatic run_random_mix(input int n_items, input int push_pct);
      int                r;
      logic [KIND_W-1:0] k;
      logic [WORD_W-1:0] v;
      for (int i = 0; i < n_items; i++) begin
         r = $urandom_range(0, 99);
         if (r < push_pct) begin
            k = KIND_PUSH;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 40)      k = KIND_POP;
            else if (r < 60) k = KIND_PEEK;
            else if (r < 98) k = KIND_SEARCH;
            else if (r < 99) k = KIND_CLEAR;
            else             k = KIND_W'($urandom_range(int'(KIND_SEARCH) + 1, int'(KIND_LAST)));
         end
         v = (k == KIND_SEARCH) ? pick_key() : pick_word();
         send_request(k, v);
         // now and then hold off until the block has caught up
         if ($urandom_range(0, 59) == 0) begin
            drain_results();
            drain_pauses++;
         end
      end
   endtask

   // Empty-stack failures, field extremes, duplicates and reserved kinds
   task automatic test_basic_requests();
      send_request(KIND_POP, '0);
      send_request(KIND_PEEK, '1);
      send_request(KIND_SEARCH, '0);
      send_request(KIND_PUSH, {1'b1, {(WORD_W-1){1'b0}}});
      send_request(KIND_PUSH, {1'b0, {(WORD_W-1){1'b1}}});
      send_request(KIND_PUSH, '0);
      send_request(KIND_PUSH, '1);
      send_request(KIND_PUSH, WORD_W'(7));
      send_request(KIND_PUSH, WORD_W'(7));
      send_request(KIND_PEEK, '0);
      send_request(KIND_SEARCH, WORD_W'(7));
      send_request(KIND_SEARCH, {1'b1, {(WORD_W-1){1'b0}}});
      send_request(KIND_SEARCH, WORD_W'(12345));
      for (int k = int'(KIND_SEARCH) + 1; k <= int'(KIND_LAST); k++)
         send_request(KIND_W'(k), $urandom());
      send_request(KIND_POP, '0);
      send_request(KIND_POP, '1);
      send_request(KIND_PEEK, '0);
      send_request(KIND_CLEAR, '1);
      send_request(KIND_POP, '0);
      send_request(KIND_SEARCH, '1);
   endtask

   // Zero, one, saturated and lowered-below-count capacity
   task automatic test_capacity_limits();
      write_capacity(CAP_W'(0));
      send_request(KIND_PUSH, WORD_W'(5));
      send_request(KIND_PEEK, '0);
      write_capacity(CAP_W'(1));
      send_request(KIND_PUSH, WORD_W'(11));
      send_request(KIND_PUSH, WORD_W'(12));
      send_request(KIND_SEARCH, WORD_W'(11));
      // above the physical depth: must saturate
      write_capacity('1);
      while (shadow_count < DEPTH) send_request(KIND_PUSH, $urandom());
      send_request(KIND_PUSH, WORD_W'(13));
      send_request(KIND_SEARCH, WORD_W'(11));
      send_request(KIND_SEARCH, $urandom());
      // lowered below the fill level: entries stay, pushes rejected
      write_capacity(CAP_W'(3));
      send_request(KIND_PUSH, WORD_W'(14));
      send_request(KIND_PEEK, '0);
      while (shadow_count >= 3) send_request(KIND_POP, '0);
      send_request(KIND_PUSH, WORD_W'(15));
      send_request(KIND_PUSH, WORD_W'(16));
      send_request(KIND_CLEAR, '0);
   endtask

   task automatic test_random_phases();
      write_capacity(CAP_W'(DEPTH));
      run_random_mix(250, 75);
      run_random_mix(200, 30);
      write_capacity('1);
      run_random_mix(200, 60);
      write_capacity(CAP_W'(5));
      run_random_mix(150, 55);
      write_capacity(CAP_W'(1));
      run_random_mix(100, 50);
      write_capacity(CAP_W'(0));
      run_random_mix(60, 50);
      write_capacity(CAP_W'(2));
      run_random_mix(100, 50);
      write_capacity(CAP_W'(DEPTH));
      run_random_mix(300, 50);
      write_capacity(CAP_W'(100));
      run_random_mix(200, 65);
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_kind        = KIND_PUSH;
      req_value       = '0;
      csr_valid       = 1'b0;
      csr_data        = '0;
      shadow_count    = 0;
      shadow_capacity = CAP_RESET;
      error_count     = 0;
      results_checked = 0;
      idle_cycles     = 0;
      burst_left      = 0;
      full_rejects    = 0;
      empty_rejects   = 0;
      search_hits     = 0;
      search_misses   = 0;
      deepest_stack   = 0;
      capacity_writes = 0;
      drain_pauses    = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_basic_requests();
      test_capacity_limits();
      test_random_phases();

      // let the last search finish and catch any stray result beat
      drain_results();
      repeat (2 * DEPTH) @(negedge clock);
      if (pending_results.size() != 0) error_count++;

      $display("checked %0d results: %0d full rejects, %0d empty rejects, %0d hits, %0d misses",
               results_checked, full_rejects, empty_rejects, search_hits, search_misses);
      $display("deepest stack %0d, %0d capacity writes, %0d drain pauses, %0d mismatches",
               deepest_stack, capacity_writes, drain_pauses, error_count);
      if (error_count == 0) begin
         $display("lifo_stack_with_search_tb: PASS");
      end else begin
         $display("lifo_stack_with_search_tb: FAIL");
      end
      $finish;
   end

endmodule
